@@ hdl/baseline_threshold_occupancy_detector_defines.svh @@
// Shared assertion macros for the occupancy detector checkers.
`ifndef BASELINE_THRESHOLD_OCCUPANCY_DETECTOR_DEFINES_SVH
`define BASELINE_THRESHOLD_OCCUPANCY_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTOD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("occupancy detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define BTOD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("occupancy detector check failed");

`endif

@@ hdl/btod_pkg.sv @@
package btod_pkg;

	// Channel count and field widths of the sample words, result words, calibration counter and register bus.
	localparam int CHANNELS      = 4;
	localparam int SAMPLE_BITS   = 12;
	localparam int THR_BITS      = 12;
	localparam int PHASE_BITS    = 8;
	localparam int CAL_BITS      = 9;
	localparam int ARR_BITS      = 16;
	localparam int OCC_CNT_BITS  = 3;
	localparam int ADDR_BITS     = 4;
	localparam int DATA_BITS     = 32;

	// Register reset values.
	localparam logic [THR_BITS-1:0]   RST_THRESHOLD = THR_BITS'(10);
	localparam logic [PHASE_BITS-1:0] RST_SETTLE    = PHASE_BITS'(10);
	localparam logic [PHASE_BITS-1:0] RST_AVERAGE   = PHASE_BITS'(25);

	// Register indexes (byte address divided by four).
	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_SETTLE    = 2'd1,
		REG_AVERAGE   = 2'd2
	} reg_idx_t;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_vec_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [THR_BITS-1:0]   threshold;
		logic [PHASE_BITS-1:0] settle;
		logic [PHASE_BITS-1:0] average;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic [CHANNELS-1:0]     occupied_mask;
		logic [OCC_CNT_BITS-1:0] occupied_count;
		logic [ARR_BITS-1:0]     arrivals_total;
		logic                    calibrating;
	} result_t;

endpackage

@@ hdl/btod_if.sv @@
// Sample channel: one converter sample per sensor channel.
interface btod_in_if import btod_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_a;
	sample_t sample_b;
	sample_t sample_c;
	sample_t sample_d;

	modport source (output valid, output sample_a, output sample_b, output sample_c,
		output sample_d, input ready);
	modport sink (input valid, input sample_a, input sample_b, input sample_c,
		input sample_d, output ready);
endinterface

// Result channel: occupancy flags, count, arrivals total and calibration flag.
interface btod_out_if import btod_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CHANNELS-1:0]     occupied_mask;
	logic [OCC_CNT_BITS-1:0] occupied_count;
	logic [ARR_BITS-1:0]     arrivals_total;
	logic                    calibrating;

	modport source (output valid, output occupied_mask, output occupied_count,
		output arrivals_total, output calibrating, input ready);
	modport sink (input valid, input occupied_mask, input occupied_count,
		input arrivals_total, input calibrating, output ready);
endinterface

@@ hdl/baseline_threshold_occupancy_detector.sv @@
// A result word is stored in the output buffer when its sample word is accepted.
// Throughput: one sample word per cycle while the two-entry output buffer has
// room; each channel's baseline and flag update completes in the accepting cycle.
// Reset clears baselines, occupancy flags, the arrivals total and the calibration
// counter, and loads the registers with threshold 10, settle 10 and average 25.
module baseline_threshold_occupancy_detector import btod_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	btod_in_if.sink              samples,
	btod_out_if.source           result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	cfg_t        cfg_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;
	logic        accept;
	logic        buf_not_full;
	sample_vec_t sample_vec;
	result_t     core_word;
	result_t     out_word;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= RST_THRESHOLD;
			cfg_q.settle    <= RST_SETTLE;
			cfg_q.average   <= RST_AVERAGE;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_THRESHOLD: cfg_q.threshold <= pwdata[THR_BITS-1:0];
				REG_SETTLE:    cfg_q.settle    <= pwdata[PHASE_BITS-1:0];
				REG_AVERAGE:   cfg_q.average   <= pwdata[PHASE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = DATA_BITS'(cfg_q.threshold);
			REG_SETTLE:    prdata = DATA_BITS'(cfg_q.settle);
			REG_AVERAGE:   prdata = DATA_BITS'(cfg_q.average);
			default:       prdata = '0;
		endcase
	end

	// Input handshake.
	assign samples.ready = buf_not_full;
	assign accept        = samples.valid && buf_not_full;
	assign sample_vec    = {samples.sample_d, samples.sample_c, samples.sample_b,
		samples.sample_a};

	btod_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.samples (sample_vec),
		.cfg     (cfg_q),
		.result  (core_word)
	);

	btod_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (core_word),
		.not_full  (buf_not_full),
		.pop_valid (result.valid),
		.pop       (result.ready),
		.pop_word  (out_word)
	);

	// Result word fields.
	assign result.occupied_mask  = out_word.occupied_mask;
	assign result.occupied_count = out_word.occupied_count;
	assign result.arrivals_total = out_word.arrivals_total;
	assign result.calibrating    = out_word.calibrating;

endmodule

@@ hdl/btod_core.sv @@
module btod_core import btod_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  sample_vec_t samples,
	input  cfg_t        cfg,
	output result_t     result
);

	sample_t             baseline_q [CHANNELS];
	sample_t             baseline_d [CHANNELS];
	logic [CHANNELS-1:0] flags_q;
	logic [CHANNELS-1:0] flags_d;
	logic [ARR_BITS-1:0] arrivals_q;
	logic [ARR_BITS-1:0] arrivals_d;
	logic [CAL_BITS-1:0] cal_cnt_q;
	logic [CAL_BITS-1:0] cal_cnt_d;

	logic [CAL_BITS-1:0]     total_cal;
	logic                    calib;
	logic                    settle_ph;
	logic [SAMPLE_BITS:0]    avg_sum;
	logic [SAMPLE_BITS:0]    limit;
	logic [CHANNELS-1:0]     mask;
	logic [OCC_CNT_BITS-1:0] count;
	logic [OCC_CNT_BITS-1:0] new_arr;
	logic [ARR_BITS:0]       arr_sum;

	// Per-channel baseline update or threshold compare, and arrivals count.
	always_comb begin
		total_cal = {1'b0, cfg.settle} + {1'b0, cfg.average};
		calib     = cal_cnt_q < total_cal;
		settle_ph = cal_cnt_q < {1'b0, cfg.settle};
		mask      = '0;
		count     = '0;
		new_arr   = '0;
		flags_d   = '0;
		avg_sum   = '0;
		limit     = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			baseline_d[i] = baseline_q[i];
			avg_sum = {1'b0, baseline_q[i]} + {1'b0, samples[i]};
			// Occupied when baseline - sample > threshold, i.e. baseline > sample + threshold.
			limit = {1'b0, samples[i]} + {1'b0, cfg.threshold};
			if (calib) begin
				baseline_d[i] = settle_ph ? samples[i] : avg_sum[SAMPLE_BITS:1];
			end else if ({1'b0, baseline_q[i]} > limit) begin
				mask[i]    = 1'b1;
				flags_d[i] = 1'b1;
				count      = count + OCC_CNT_BITS'(1);
				if (!flags_q[i]) begin
					new_arr = new_arr + OCC_CNT_BITS'(1);
				end
			end
		end
		arr_sum    = {1'b0, arrivals_q} + (ARR_BITS + 1)'(new_arr);
		arrivals_d = arr_sum[ARR_BITS] ? '1 : arr_sum[ARR_BITS-1:0];
		cal_cnt_d  = calib ? cal_cnt_q + CAL_BITS'(1) : cal_cnt_q;

		result.occupied_mask  = mask;
		result.occupied_count = count;
		result.arrivals_total = arrivals_d;
		result.calibrating    = calib;
	end

	// Detector state advances once per accepted sample word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				baseline_q[i] <= '0;
			end
			flags_q    <= '0;
			arrivals_q <= '0;
			cal_cnt_q  <= '0;
		end else if (accept) begin
			for (int i = 0; i < CHANNELS; i++) begin
				baseline_q[i] <= baseline_d[i];
			end
			flags_q    <= flags_d;
			arrivals_q <= arrivals_d;
			cal_cnt_q  <= cal_cnt_d;
		end
	end

endmodule

@@ hdl/btod_outbuf.sv @@
module btod_outbuf import btod_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_word,
	output logic    not_full,
	output logic    pop_valid,
	input  logic    pop,
	output result_t pop_word
);

	// Two entries, so a new word is taken while one waits at the output.
	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign not_full  = fill_q != 2'd2;
	assign pop_valid = fill_q != 2'd0;
	assign pop_word  = entry_q[rd_ptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && pop_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

@@ hdl/btod_checker.sv @@
`include "baseline_threshold_occupancy_detector_defines.svh"

module btod_checker import btod_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [CHANNELS-1:0]     occupied_mask,
	input logic [OCC_CNT_BITS-1:0] occupied_count,
	input logic [ARR_BITS-1:0]     arrivals_total,
	input logic                    calibrating
);

	logic [ARR_BITS-1:0] last_total_q;

	// Arrivals total of the last word taken from the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (out_valid && out_ready) begin
			last_total_q <= arrivals_total;
		end
	end

	// A stalled result word stays offered and unchanged.
	`BTOD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({occupied_mask, occupied_count, arrivals_total, calibrating}))
	// The occupied count matches the flags.
	`BTOD_ASSERT_SAME(a_count_match, out_valid, 32'(occupied_count) == $countones(occupied_mask))
	// Calibration words report no occupancy.
	`BTOD_ASSERT_SAME(a_calib_free, out_valid && calibrating, occupied_mask == '0)
	// The arrivals total never goes down from one word to the next.
	`BTOD_ASSERT_SAME(a_total_mono, out_valid, arrivals_total >= last_total_q)

endmodule

bind baseline_threshold_occupancy_detector btod_checker u_btod_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.occupied_mask  (result.occupied_mask),
	.occupied_count (result.occupied_count),
	.arrivals_total (result.arrivals_total),
	.calibrating    (result.calibrating)
);
